### design/led_pixel_gamma_backlight_temperature_core_assert.svh
// Assertion macros shared by the design files.
`ifndef LED_PIXEL_GAMMA_BACKLIGHT_TEMPERATURE_CORE_ASSERT_SVH
`define LED_PIXEL_GAMMA_BACKLIGHT_TEMPERATURE_CORE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define LPGBT_ASSERT_NOW(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("lpgbt: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define LPGBT_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("lpgbt: next-cycle check failed");

`endif

### design/lpgbt_pkg.sv
package lpgbt_pkg;

   localparam int ColorWidth     = 8;
   localparam int TableDepth     = 256;
   localparam int TableAddrWidth = 8;
   localparam int ChanWidth      = 2;
   localparam int CsrAddrWidth   = 3;
   localparam int CsrDataWidth   = 8;
   localparam int ProductWidth   = 2 * ColorWidth;

   typedef enum logic {
      KindPixel = 1'b0,
      KindTable = 1'b1
   } kind_type;

   typedef enum logic [ChanWidth-1:0] {
      ChanRed   = 2'd0,
      ChanGreen = 2'd1,
      ChanBlue  = 2'd2
   } chan_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      RegBacklightEnable     = 3'd0,
      RegBacklightFloor      = 3'd1,
      RegBacklightPerChannel = 3'd2,
      RegTempGainRed         = 3'd3,
      RegTempGainGreen       = 3'd4,
      RegTempGainBlue        = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic                  backlight_enable;
      logic [ColorWidth-1:0] backlight_floor;
      logic                  backlight_per_channel;
      logic [ColorWidth-1:0] temp_gain_red;
      logic [ColorWidth-1:0] temp_gain_green;
      logic [ColorWidth-1:0] temp_gain_blue;
   } cfg_type;

   typedef struct packed {
      logic [ColorWidth-1:0] red;
      logic [ColorWidth-1:0] green;
      logic [ColorWidth-1:0] blue;
   } rgb_type;

   // Exact p / 255 for any product of two 8-bit values.
   function automatic logic [ColorWidth-1:0] div255(input logic [ProductWidth-1:0] p);
      logic [ProductWidth:0] sum;
      sum = {1'b0, p} + {{(ColorWidth + 1){1'b0}}, p[ProductWidth-1:ColorWidth]}
            + {{ProductWidth{1'b0}}, 1'b1};
      return sum[ProductWidth-1:ColorWidth];
   endfunction

endpackage

### design/lpgbt_if.sv
interface lpgbt_req_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [lpgbt_pkg::ColorWidth-1:0]   red_in;
   logic [lpgbt_pkg::ColorWidth-1:0]   green_in;
   logic [lpgbt_pkg::ColorWidth-1:0]   blue_in;
   logic [lpgbt_pkg::ChanWidth-1:0]    table_channel;
   logic [lpgbt_pkg::TableAddrWidth-1:0] table_index;
   logic [lpgbt_pkg::ColorWidth-1:0]   table_value;

   modport source (output valid, kind, red_in, green_in, blue_in, table_channel,
                   table_index, table_value, input ready);
   modport sink (input valid, kind, red_in, green_in, blue_in, table_channel,
                 table_index, table_value, output ready);
endinterface

interface lpgbt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lpgbt_pkg::ColorWidth-1:0] red_out;
   logic [lpgbt_pkg::ColorWidth-1:0] green_out;
   logic [lpgbt_pkg::ColorWidth-1:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface lpgbt_csr_if;
   logic                               valid;
   logic                               ready;
   logic [lpgbt_pkg::CsrAddrWidth-1:0] index;
   logic [lpgbt_pkg::CsrDataWidth-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/lpgbt_ram.sv
module lpgbt_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lpgbt_csr.sv
module lpgbt_csr (
   input  logic               clock,
   input  logic               reset,
   lpgbt_csr_if.sink          csr_bus,
   output lpgbt_pkg::cfg_type cfg
);

   lpgbt_pkg::cfg_type cfg_ff;
   lpgbt_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            lpgbt_pkg::RegBacklightEnable:     cfg_in.backlight_enable = csr_bus.data[0];
            lpgbt_pkg::RegBacklightFloor:      cfg_in.backlight_floor = csr_bus.data;
            lpgbt_pkg::RegBacklightPerChannel: cfg_in.backlight_per_channel = csr_bus.data[0];
            lpgbt_pkg::RegTempGainRed:         cfg_in.temp_gain_red = csr_bus.data;
            lpgbt_pkg::RegTempGainGreen:       cfg_in.temp_gain_green = csr_bus.data;
            lpgbt_pkg::RegTempGainBlue:        cfg_in.temp_gain_blue = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.backlight_enable      <= 1'b1;
         cfg_ff.backlight_floor       <= '0;
         cfg_ff.backlight_per_channel <= 1'b0;
         cfg_ff.temp_gain_red         <= '1;
         cfg_ff.temp_gain_green       <= '1;
         cfg_ff.temp_gain_blue        <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/lpgbt_grade.sv
`include "led_pixel_gamma_backlight_temperature_core_assert.svh"

module lpgbt_grade (
   input  logic               clock,
   input  logic               reset,
   input  lpgbt_pkg::cfg_type cfg,
   input  logic               pix_valid,
   input  lpgbt_pkg::rgb_type pix,
   output logic               pix_load,
   lpgbt_rsp_if.source        rsp_bus
);

   localparam int CW = lpgbt_pkg::ColorWidth;
   localparam int PW = lpgbt_pkg::ProductWidth;

   lpgbt_pkg::rgb_type     lit;
   logic [CW-1:0]          lo;
   logic [CW-1:0]          hi;
   logic [CW:0]            mid_sum;
   logic                   floor_on;

   logic                   prod_valid_ff;
   logic                   prod_valid_in;
   logic [PW-1:0]          prod_red_ff;
   logic [PW-1:0]          prod_green_ff;
   logic [PW-1:0]          prod_blue_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   lpgbt_pkg::rgb_type     out_ff;

   logic                   out_load;
   logic                   prod_load;

   // Each stage may load when it is empty or the stage after it moves on.
   assign out_load  = !out_valid_ff || rsp_bus.ready;
   assign prod_load = !prod_valid_ff || out_load;
   assign pix_load  = !pix_valid || prod_load;

   // Backlight floor on the gamma-mapped pixel.
   always_comb begin
      lo = (pix.red < pix.green) ? pix.red : pix.green;
      lo = (lo < pix.blue) ? lo : pix.blue;
      hi = (pix.red > pix.green) ? pix.red : pix.green;
      hi = (hi > pix.blue) ? hi : pix.blue;
      mid_sum = {1'b0, lo} + {1'b0, hi};
      floor_on = cfg.backlight_enable && (cfg.backlight_floor != '0);
      lit = pix;
      if (floor_on) begin
         if (cfg.backlight_per_channel) begin
            if (pix.red < cfg.backlight_floor) begin
               lit.red = cfg.backlight_floor;
            end
            if (pix.green < cfg.backlight_floor) begin
               lit.green = cfg.backlight_floor;
            end
            if (pix.blue < cfg.backlight_floor) begin
               lit.blue = cfg.backlight_floor;
            end
         end else if (mid_sum[CW:1] < cfg.backlight_floor) begin
            lit.red   = cfg.backlight_floor;
            lit.green = cfg.backlight_floor;
            lit.blue  = cfg.backlight_floor;
         end
      end
   end

   assign prod_valid_in = prod_load ? pix_valid : prod_valid_ff;
   assign out_valid_in  = out_load ? prod_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_load) begin
         prod_red_ff   <= {{CW{1'b0}}, lit.red} * {{CW{1'b0}}, cfg.temp_gain_red};
         prod_green_ff <= {{CW{1'b0}}, lit.green} * {{CW{1'b0}}, cfg.temp_gain_green};
         prod_blue_ff  <= {{CW{1'b0}}, lit.blue} * {{CW{1'b0}}, cfg.temp_gain_blue};
      end
      if (out_load) begin
         out_ff.red   <= lpgbt_pkg::div255(prod_red_ff);
         out_ff.green <= lpgbt_pkg::div255(prod_green_ff);
         out_ff.blue  <= lpgbt_pkg::div255(prod_blue_ff);
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.red_out   = out_ff.red;
   assign rsp_bus.green_out = out_ff.green;
   assign rsp_bus.blue_out  = out_ff.blue;

   // A product behind a stalled result must stay, red and blue unchanged.
   `LPGBT_ASSERT_NEXT(prod_held_a, prod_valid_ff && out_valid_ff && !rsp_bus.ready,
      prod_valid_ff && $stable(prod_red_ff) && $stable(prod_blue_ff))

endmodule

### design/led_pixel_gamma_backlight_temperature_core.sv
// LED pixel correction core: gamma lookup, backlight floor, white-balance gain.
// Input channel req_bus: each beat is either a pixel (kind pixel) or a write
// of one gamma table entry (kind table). Table writes produce no result; a
// pixel produces exactly one result beat on rsp_bus, in order.
// Configuration port csr_bus: register writes, always ready, to be issued
// only while no pixel is in flight.
// A pixel passes three registered stages on its way to rsp_bus: gamma
// table read, floor and multiply, divide by 255.
// Throughput: one beat per cycle, set by the single-ported write / single
// read of each gamma table and the three result stages, until a stall fills them.
// A table write is visible to a pixel accepted in the very next cycle.
// When the receiver stalls, results collect in the three stages; req_bus
// stays ready until all of them are full, then waits for rsp_bus.ready.
// Reset clears the stage valid flags and loads the register defaults; the
// gamma tables are not cleared and must be loaded before use.
`include "led_pixel_gamma_backlight_temperature_core_assert.svh"

module led_pixel_gamma_backlight_temperature_core (
   input  logic       clock,
   input  logic       reset,
   lpgbt_req_if.sink  req_bus,
   lpgbt_rsp_if.source rsp_bus,
   lpgbt_csr_if.sink  csr_bus
);

   localparam int CW = lpgbt_pkg::ColorWidth;

   lpgbt_pkg::cfg_type cfg;
   lpgbt_pkg::rgb_type looked_up;
   logic               pix_load;
   logic               accept;
   logic               is_table;
   logic               wr_red;
   logic               wr_green;
   logic               wr_blue;
   logic               pix_valid_ff;
   logic               pix_valid_in;

   assign req_bus.ready = pix_load;
   assign accept        = req_bus.valid && pix_load;
   assign is_table      = (req_bus.kind == lpgbt_pkg::KindTable);

   assign wr_red   = accept && is_table && (req_bus.table_channel == lpgbt_pkg::ChanRed);
   assign wr_green = accept && is_table && (req_bus.table_channel == lpgbt_pkg::ChanGreen);
   assign wr_blue  = accept && is_table && (req_bus.table_channel == lpgbt_pkg::ChanBlue);

   assign pix_valid_in = pix_load ? (accept && !is_table) : pix_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
      end
   end

   lpgbt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   lpgbt_ram #(.Width(CW), .Depth(lpgbt_pkg::TableDepth)) u_red_table (
      .clock   (clock),
      .wr_en   (wr_red),
      .wr_addr (req_bus.table_index),
      .wr_data (req_bus.table_value),
      .rd_en   (pix_load),
      .rd_addr (req_bus.red_in),
      .rd_data (looked_up.red)
   );

   lpgbt_ram #(.Width(CW), .Depth(lpgbt_pkg::TableDepth)) u_green_table (
      .clock   (clock),
      .wr_en   (wr_green),
      .wr_addr (req_bus.table_index),
      .wr_data (req_bus.table_value),
      .rd_en   (pix_load),
      .rd_addr (req_bus.green_in),
      .rd_data (looked_up.green)
   );

   lpgbt_ram #(.Width(CW), .Depth(lpgbt_pkg::TableDepth)) u_blue_table (
      .clock   (clock),
      .wr_en   (wr_blue),
      .wr_addr (req_bus.table_index),
      .wr_data (req_bus.table_value),
      .rd_en   (pix_load),
      .rd_addr (req_bus.blue_in),
      .rd_data (looked_up.blue)
   );

   lpgbt_grade u_grade (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pix_valid (pix_valid_ff),
      .pix       (looked_up),
      .pix_load  (pix_load),
      .rsp_bus   (rsp_bus)
   );

   // An accepted pixel always occupies the lookup stage next cycle.
   `LPGBT_ASSERT_NEXT(pix_enters_a, accept && !is_table, pix_valid_ff)
   // A stalled lookup stage keeps its table data.
   `LPGBT_ASSERT_NEXT(lookup_held_a, pix_valid_ff && !pix_load,
      pix_valid_ff && $stable(looked_up))
   // No table write may coincide with a stalled input.
   `LPGBT_ASSERT_NOW(write_gated_a, wr_red || wr_green || wr_blue, req_bus.ready)

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import lpgbt_pkg::*;

   localparam logic [ChanWidth-1:0]    ChanUnused   = 2'd3;
   localparam logic [CsrAddrWidth-1:0] RegSpareLow  = 3'd6;
   localparam logic [CsrAddrWidth-1:0] RegSpareHigh = 3'd7;
   localparam int PhaseCount    = 8;
   localparam int BeatsPerPhase = 104;
   localparam int MaxGap        = 16;
   localparam int HoldCycles    = 64;
   localparam int DrainCycles   = 8;
   localparam int IdleLimit     = 2000;
   localparam int MaxReports    = 10;

   typedef struct packed {
      kind_type                  kind;
      rgb_type                   pixel;
      logic [ChanWidth-1:0]      channel;
      logic [TableAddrWidth-1:0] index;
      logic [ColorWidth-1:0]     value;
   } req_beat_type;

   class pixel_scoreboard;
      logic [ColorWidth-1:0] red_lut[TableDepth];
      logic [ColorWidth-1:0] green_lut[TableDepth];
      logic [ColorWidth-1:0] blue_lut[TableDepth];
      cfg_type settings;
      rgb_type pending_pixels[$];
      int      errors;
      int      results;

      function new();
         settings = '{1'b1, 8'd0, 1'b0, 8'd255, 8'd255, 8'd255};
         errors   = 0;
         results  = 0;
      endfunction

      function void note_error(string what);
         errors++;
         if (errors <= MaxReports)
            $display("[%0t] pixel result %0d: %s", $realtime, results, what);
      endfunction

      function void write_reg(logic [CsrAddrWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            RegBacklightEnable:     settings.backlight_enable = data[0];
            RegBacklightFloor:      settings.backlight_floor = data;
            RegBacklightPerChannel: settings.backlight_per_channel = data[0];
            RegTempGainRed:         settings.temp_gain_red = data;
            RegTempGainGreen:       settings.temp_gain_green = data;
            RegTempGainBlue:        settings.temp_gain_blue = data;
            default: ;
         endcase
      endfunction

      // Truncating value * gain / 255.
      function logic [ColorWidth-1:0] apply_gain(logic [ColorWidth-1:0] v,
                                                 logic [ColorWidth-1:0] g);
         int unsigned product;
         product = int'(v) * int'(g);
         return ColorWidth'(product / 255);
      endfunction

      function void note_beat(req_beat_type b);
         logic [ColorWidth-1:0] r, g, bl, lo, hi, level;
         logic [ColorWidth:0]   mid;
         rgb_type               want;
         if (b.kind == KindTable) begin
            case (b.channel)
               ChanRed:   red_lut[b.index] = b.value;
               ChanGreen: green_lut[b.index] = b.value;
               ChanBlue:  blue_lut[b.index] = b.value;
               default: ;
            endcase
            return;
         end
         r     = red_lut[b.pixel.red];
         g     = green_lut[b.pixel.green];
         bl    = blue_lut[b.pixel.blue];
         level = settings.backlight_floor;
         if (settings.backlight_enable && level != '0) begin
            if (settings.backlight_per_channel) begin
               if (r < level) r = level;
               if (g < level) g = level;
               if (bl < level) bl = level;
            end else begin
               lo = r;
               if (g < lo) lo = g;
               if (bl < lo) lo = bl;
               hi = r;
               if (g > hi) hi = g;
               if (bl > hi) hi = bl;
               mid = ({1'b0, lo} + {1'b0, hi}) >> 1;
               // A pixel dark by its min-max midpoint is lifted to the floor gray.
               if (mid < {1'b0, level}) begin
                  r  = level;
                  g  = level;
                  bl = level;
               end
            end
         end
         want.red   = apply_gain(r, settings.temp_gain_red);
         want.green = apply_gain(g, settings.temp_gain_green);
         want.blue  = apply_gain(bl, settings.temp_gain_blue);
         pending_pixels.push_back(want);
      endfunction

      function void compare_field(string field, logic [ColorWidth-1:0] want,
                                  logic [ColorWidth-1:0] got);
         if (got !== want)
            note_error($sformatf("%s expected %0d, got %0d", field, want, got));
      endfunction

      function void check_pixel(rgb_type got);
         rgb_type want;
         if (pending_pixels.size() == 0) begin
            note_error($sformatf("unexpected beat %0d/%0d/%0d",
                                 got.red, got.green, got.blue));
         end else begin
            want = pending_pixels.pop_front();
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
         end
         results++;
      endfunction

      function void close_out();
         if (pending_pixels.size() != 0)
            note_error($sformatf("%0d pixels never answered", pending_pixels.size()));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   lpgbt_req_if req_bus ();
   lpgbt_rsp_if rsp_bus ();
   lpgbt_csr_if csr_bus ();

   led_pixel_gamma_backlight_temperature_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pixel_scoreboard board = new();

   bit hold_pending = 1'b0;
   int req_gap_max  = 0;
   int rsp_gap_max  = 0;
   int idle_cycles  = 0;

   // Gamma entries loaded so far; pixels only look up these.
   bit                        is_loaded[3][TableDepth];
   logic [TableAddrWidth-1:0] red_idx[$];
   logic [TableAddrWidth-1:0] green_idx[$];
   logic [TableAddrWidth-1:0] blue_idx[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic req_beat_type table_beat(logic [ChanWidth-1:0] ch,
                                               logic [TableAddrWidth-1:0] idx,
                                               logic [ColorWidth-1:0] val);
      req_beat_type b;
      b.kind    = KindTable;
      b.pixel   = rgb_type'($urandom);
      b.channel = ch;
      b.index   = idx;
      b.value   = val;
      if (ch != ChanUnused && !is_loaded[ch][idx]) begin
         is_loaded[ch][idx] = 1'b1;
         case (ch)
            ChanRed:   red_idx.push_back(idx);
            ChanGreen: green_idx.push_back(idx);
            default:   blue_idx.push_back(idx);
         endcase
      end
      return b;
   endfunction

   function automatic req_beat_type pixel_beat(logic [ColorWidth-1:0] r,
                                               logic [ColorWidth-1:0] g,
                                               logic [ColorWidth-1:0] bl);
      req_beat_type b;
      b.kind    = KindPixel;
      b.pixel   = '{r, g, bl};
      b.channel = ChanWidth'($urandom);
      b.index   = TableAddrWidth'($urandom);
      b.value   = ColorWidth'($urandom);
      return b;
   endfunction

   function automatic req_beat_type random_beat();
      logic [ChanWidth-1:0] ch;
      if ($urandom_range(0, 3) != 0)
         return pixel_beat(red_idx[$urandom_range(0, red_idx.size() - 1)],
                           green_idx[$urandom_range(0, green_idx.size() - 1)],
                           blue_idx[$urandom_range(0, blue_idx.size() - 1)]);
      ch = ($urandom_range(0, 9) == 0) ? ChanUnused : ChanWidth'($urandom_range(0, 2));
      return table_beat(ch, TableAddrWidth'($urandom), ColorWidth'($urandom));
   endfunction

   function automatic cfg_type phase_settings(int phase);
      case (phase)
         0:       return '{1'b1, 8'd0, 1'b0, 8'd255, 8'd255, 8'd255};
         1:       return '{1'b1, 8'd255, 1'b0, 8'd255, 8'd255, 8'd255};
         2:       return '{1'b1, 8'd128, 1'b1, 8'd255, 8'd0, 8'd128};
         3:       return '{1'b0, 8'd200, 1'b1, 8'd1, 8'd254, 8'd255};
         4:       return '{1'b1, 8'd1, 1'b0, 8'd0, 8'd0, 8'd0};
         5:       return '{1'b1, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255};
         default: return cfg_type'({$urandom, $urandom});
      endcase
   endfunction

   task automatic send_beat(req_beat_type b);
      int   gap;
      logic taken;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= b.kind;
      req_bus.red_in        <= b.pixel.red;
      req_bus.green_in      <= b.pixel.green;
      req_bus.blue_in       <= b.pixel.blue;
      req_bus.table_channel <= b.channel;
      req_bus.table_index   <= b.index;
      req_bus.table_value   <= b.value;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      board.note_beat(b);
   endtask

   task automatic write_csr(logic [CsrAddrWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      logic taken;
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do begin
         @(negedge clock);
         taken = csr_bus.ready;
         @(posedge clock);
      end while (!taken);
      board.write_reg(idx, data);
   endtask

   task automatic write_settings(cfg_type c, bit with_spare);
      write_csr(RegBacklightEnable, CsrDataWidth'(c.backlight_enable));
      write_csr(RegBacklightFloor, c.backlight_floor);
      write_csr(RegBacklightPerChannel, CsrDataWidth'(c.backlight_per_channel));
      write_csr(RegTempGainRed, c.temp_gain_red);
      write_csr(RegTempGainGreen, c.temp_gain_green);
      write_csr(RegTempGainBlue, c.temp_gain_blue);
      // Writes past the last register must not alias onto one of them.
      if (with_spare) begin
         write_csr(RegSpareLow, CsrDataWidth'($urandom));
         write_csr(RegSpareHigh, CsrDataWidth'($urandom));
      end
      csr_bus.valid <= 1'b0;
   endtask

   // Table writes leave no result behind, so an extra idle wait lets them land.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_pixels.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin : rsp_side
      int      gap;
      logic    taken;
      rgb_type got;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_pending) begin
            gap          = HoldCycles;
            hold_pending = 1'b0;
         end else begin
            gap = (rsp_gap_max == 0) ? 0 : $urandom_range(0, rsp_gap_max);
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do begin
            @(negedge clock);
            taken     = rsp_bus.valid;
            got.red   = rsp_bus.red_out;
            got.green = rsp_bus.green_out;
            got.blue  = rsp_bus.blue_out;
            @(posedge clock);
         end while (!taken);
         board.check_pixel(got);
      end
   end

   initial begin : stimulus
      int phase;
      int n;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.kind          <= KindPixel;
      req_bus.red_in        <= '0;
      req_bus.green_in      <= '0;
      req_bus.blue_in       <= '0;
      req_bus.table_channel <= ChanRed;
      req_bus.table_index   <= '0;
      req_bus.table_value   <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= RegBacklightEnable;
      csr_bus.data          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Back to back under the reset settings: table extremes, an ignored
      // write to the unused channel, and a lookup right after an overwrite.
      send_beat(table_beat(ChanRed, 8'd0, 8'd0));
      send_beat(table_beat(ChanGreen, 8'd0, 8'd0));
      send_beat(table_beat(ChanBlue, 8'd0, 8'd0));
      send_beat(table_beat(ChanRed, 8'd255, 8'd255));
      send_beat(table_beat(ChanGreen, 8'd255, 8'd255));
      send_beat(table_beat(ChanBlue, 8'd255, 8'd255));
      send_beat(table_beat(ChanRed, 8'h55, 8'hAA));
      send_beat(table_beat(ChanGreen, 8'hAA, 8'h55));
      send_beat(table_beat(ChanBlue, 8'h55, 8'h80));
      send_beat(table_beat(ChanUnused, 8'd0, 8'hFF));
      send_beat(pixel_beat(8'd0, 8'd0, 8'd0));
      send_beat(pixel_beat(8'd255, 8'd255, 8'd255));
      send_beat(pixel_beat(8'd0, 8'd255, 8'd0));
      send_beat(pixel_beat(8'd255, 8'd0, 8'd255));
      send_beat(pixel_beat(8'h55, 8'hAA, 8'h55));
      send_beat(table_beat(ChanRed, 8'd0, 8'h33));
      send_beat(pixel_beat(8'd0, 8'hAA, 8'd255));
      drain_results();

      for (phase = 0; phase < PhaseCount; phase++) begin
         write_settings(phase_settings(phase), phase[0]);
         req_gap_max = (phase % 3 == 1) ? 0 : MaxGap;
         rsp_gap_max = (phase % 2 == 0) ? MaxGap : 0;
         for (n = 0; n < BeatsPerPhase; n++) begin
            // The sender runs flat out here, so the long stall backs up the input.
            if (phase == 4 && n == BeatsPerPhase / 2) hold_pending = 1'b1;
            if (phase == 5 && n == BeatsPerPhase / 2) drain_results();
            send_beat(random_beat());
         end
         drain_results();
      end

      board.close_out();
      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### led_pixel_gamma_backlight_temperature_core.f
+incdir+design
design/lpgbt_pkg.sv
design/lpgbt_if.sv
design/lpgbt_ram.sv
design/lpgbt_csr.sv
design/lpgbt_grade.sv
design/led_pixel_gamma_backlight_temperature_core.sv
bench/tb.sv
